### rtl/c8vm_pkg.sv
// Shared types and constants for the CHIP-8 execute unit.
`default_nettype none
package c8vm_pkg;
	localparam logic [1:0] OP_EXEC  = 2'd0;
	localparam logic [1:0] OP_WRMEM = 2'd1;
	localparam logic [1:0] OP_RDROW = 2'd2;

	localparam logic [1:0] FLT_NONE  = 2'd0;
	localparam logic [1:0] FLT_BADOP = 2'd1;
	localparam logic [1:0] FLT_OVER  = 2'd2;
	localparam logic [1:0] FLT_UNDER = 2'd3;

	localparam int unsigned MEM_AW    = 12;
	localparam int unsigned ROW_AW    = 5;
	localparam int unsigned FONT_SIZE = 80;
	localparam logic [11:0] PC_RESET  = 12'h200;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] opcode;
		logic [15:0] keys_down;
		logic [7:0]  random_byte;
		logic [11:0] address;
		logic [7:0]  data_byte;
		logic [4:0]  row_index;
	} vm_in_t;

	typedef struct packed {
		logic [11:0] program_counter;
		logic [15:0] index_value;
		logic [63:0] display_row;
		logic        waiting_for_key;
		logic        display_changed;
		logic [7:0]  sound_level;
		logic [1:0]  fault;
	} vm_out_t;

	function automatic logic [7:0] font_byte(input logic [6:0] a);
		logic [7:0] r;
		case (a)
			7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22,
			7'd25, 7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42,
			7'd44, 7'd45, 7'd47, 7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70,
			7'd72, 7'd74, 7'd75, 7'd77: r = 8'hF0;
			7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46,
			7'd51, 7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68: r = 8'h90;
			7'd5, 7'd37: r = 8'h20;
			7'd6: r = 8'h60;
			7'd7, 7'd8: r = 8'h20;
			7'd9: r = 8'h70;
			7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: r = 8'h10;
			7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76,
			7'd78, 7'd79: r = 8'h80;
			7'd38, 7'd39: r = 8'h40;
			7'd55, 7'd57, 7'd65, 7'd69: r = 8'hE0;
			default: r = 8'h00;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

### rtl/c8vm_if.sv
// Valid/ready channel carrying one payload word.
`default_nettype none
interface c8vm_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/c8vm_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module c8vm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

### rtl/bytecode_vm_execute_unit.sv
// CHIP-8 execute unit: sequencer with one shared ALU over memory and frame store.
// Register ops pass through the decode and result states; BCD writes its three digits
// in turn; block copy and sprite draw read each memory byte through the read, wait and
// use states (up to 16 bytes for a copy); a screen clear zeroes the 32 frame rows in turn.
// After reset a clearing pass fills all 4096 memory bytes (font, then zeros);
// no item is accepted until it ends. One item at a time; the result sits in an
// output register and the next item is taken once it has been taken.
// arst_n asynchronously clears the control and architectural registers except the return stack.
`default_nettype none
module bytecode_vm_execute_unit
	import c8vm_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	c8vm_if.sink     in_ch,
	c8vm_if.source   out_ch
);
	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned SAW = $clog2(STACK_DEPTH);

	localparam logic [3:0] ST_INIT = 4'd0, ST_IDLE = 4'd1, ST_DEC = 4'd2,
		ST_MRD = 4'd3, ST_MWAIT = 4'd4, ST_MUSE = 4'd5, ST_CLR = 4'd6,
		ST_RROW = 4'd7, ST_DONE = 4'd8, ST_OUT = 4'd9, ST_BCD = 4'd10;

	logic [3:0]  state_q;
	vm_in_t      req_q;
	logic [7:0]  v_q [16];
	logic [15:0] i_q;
	logic [11:0] pc_q;
	logic [SPW-1:0] sp_q;
	logic [11:0] stk_q [STACK_DEPTH];
	logic [7:0]  dt_q, st_q;
	logic [63:0] fb_q [32];
	logic [4:0]  cnt_q;
	logic [11:0] init_q;
	logic        hit_q, chg_q, wait_q;
	logic [1:0]  flt_q;
	logic [7:0]  bcd_q;
	logic [1:0]  bdig_q;
	vm_out_t     res_q;
	logic        ovalid_q;

	// memory port
	logic        m_we;
	logic [11:0] m_addr;
	logic [7:0]  m_wd, m_rd;
	c8vm_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));

	logic [3:0] ox, oy, on;
	logic [7:0] kk, vx, vy;
	assign ox = req_q.opcode[11:8];
	assign oy = req_q.opcode[7:4];
	assign on = req_q.opcode[3:0];
	assign kk = req_q.opcode[7:0];
	assign vx = v_q[ox];
	assign vy = v_q[oy];

	// shared ALU
	logic [8:0] sum;
	logic [7:0] alu_b;
	logic       alu_sub;
	assign sum = alu_sub ? {1'b0, vx} - {1'b0, alu_b} : {1'b0, vx} + {1'b0, alu_b};

	// subtract results once VF holds the new flag (x or y = F read the flag)
	logic [7:0] f5, d5, f7, d7;
	assign f5 = {7'd0, !sum[8]};
	assign d5 = ((ox == 4'hF) ? f5 : vx) - ((oy == 4'hF) ? f5 : vy);
	assign f7 = {7'd0, vy >= vx};
	assign d7 = ((oy == 4'hF) ? f7 : vy) - ((ox == 4'hF) ? f7 : vx);

	// BCD digits: hundreds by compare, tens by reciprocal multiply (exact below 1029)
	logic [7:0]  bcd_h, bcd_r, bcd_o;
	logic [15:0] bcd_m;
	logic [3:0]  bcd_t;
	assign bcd_h = (vx >= 8'd200) ? 8'd2 : ((vx >= 8'd100) ? 8'd1 : 8'd0);
	assign bcd_r = vx - ((vx >= 8'd200) ? 8'd200 : ((vx >= 8'd100) ? 8'd100 : 8'd0));
	assign bcd_m = {8'd0, bcd_r} * 16'd205;
	assign bcd_t = bcd_m[14:11];
	assign bcd_o = bcd_r - {1'b0, bcd_t, 3'b000} - {3'b000, bcd_t, 1'b0};

	logic [11:0] mbase;
	assign mbase = i_q[11:0] + {7'd0, cnt_q};
	logic [5:0]  sx;
	logic [4:0]  ry;
	logic [63:0] sprite;
	assign sx = vx[5:0];
	assign ry = vy[4:0] + cnt_q;
	assign sprite = ({m_rd, 56'd0} >> sx) | ({m_rd, 56'd0} << (7'd64 - {1'b0, sx}));

	logic [3:0] lowkey;
	always_comb begin
		lowkey = 4'd0;
		for (int k = 15; k >= 0; k--)
			if (req_q.keys_down[k]) lowkey = 4'(k);
	end
	logic keyp;
	assign keyp = (vx < 8'd16) && req_q.keys_down[vx[3:0]];

	always_comb begin
		m_we = 1'b0; m_addr = mbase; m_wd = 8'd0;
		alu_b = vy; alu_sub = 1'b0;
		case (state_q)
			ST_INIT: begin
				m_we = 1'b1; m_addr = init_q;
				m_wd = (init_q < 12'(FONT_SIZE)) ? font_byte(init_q[6:0]) : 8'd0;
			end
			ST_MUSE: if (kk == 8'h55) begin
				m_we = 1'b1; m_wd = v_q[cnt_q[3:0]];
			end
			ST_BCD: begin
				m_we = 1'b1; m_addr = i_q[11:0] + {10'd0, bdig_q};
				m_wd = bcd_q;
			end
			ST_IDLE: begin
				m_addr = in_ch.data.address;
				m_we = in_ch.valid && !ovalid_q && in_ch.data.operation == OP_WRMEM;
				m_wd = in_ch.data.data_byte;
			end
			ST_DEC: begin
				if (req_q.opcode[15:12] == 4'h3 || req_q.opcode[15:12] == 4'h4 ||
					req_q.opcode[15:12] == 4'h7) alu_b = kk;
				if (req_q.opcode[15:12] == 4'h8 && (on == 4'h5 || on == 4'h7))
					alu_sub = 1'b1;
			end
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE) && !ovalid_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT; init_q <= '0; ovalid_q <= 1'b0;
			i_q <= '0; pc_q <= PC_RESET; sp_q <= '0; dt_q <= '0; st_q <= '0;
			cnt_q <= '0; hit_q <= 1'b0; chg_q <= 1'b0; wait_q <= 1'b0;
			flt_q <= FLT_NONE; bcd_q <= '0; bdig_q <= '0;
			for (int k = 0; k < 16; k++) v_q[k] <= '0;
			for (int k = 0; k < 32; k++) fb_q[k] <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					init_q <= init_q + 12'd1;
					if (init_q == 12'hFFF) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_ch.valid && in_ch.ready) begin
					req_q <= in_ch.data;
					cnt_q <= '0; hit_q <= 1'b0; chg_q <= 1'b0; wait_q <= 1'b0;
					flt_q <= FLT_NONE;
					state_q <= (in_ch.data.operation == OP_EXEC) ? ST_DEC : ST_DONE;
				end
				ST_DEC: begin
					state_q <= ST_DONE;
					case (req_q.opcode[15:12])
						4'h0: begin
							if (req_q.opcode == 16'h00E0) state_q <= ST_CLR;
							else if (req_q.opcode == 16'h00EE) begin
								if (sp_q == '0) flt_q <= FLT_UNDER;
								else begin
									pc_q <= stk_q[SAW'(sp_q - 1'b1)];
									sp_q <= sp_q - 1'b1;
								end
							end else flt_q <= FLT_BADOP;
						end
						4'h1: pc_q <= req_q.opcode[11:0];
						4'h2: begin
							if (sp_q >= SPW'(STACK_DEPTH)) flt_q <= FLT_OVER;
							else begin
								stk_q[SAW'(sp_q)] <= pc_q;
								sp_q <= sp_q + 1'b1;
								pc_q <= req_q.opcode[11:0];
							end
						end
						4'h3: if (vx == kk) pc_q <= pc_q + 12'd2;
						4'h4: if (vx != kk) pc_q <= pc_q + 12'd2;
						4'h5: if (vx == vy) pc_q <= pc_q + 12'd2;
						4'h6: v_q[ox] <= kk;
						4'h7: v_q[ox] <= sum[7:0];
						4'h8: case (on)
							4'h0: v_q[ox] <= vy;
							4'h1: v_q[ox] <= vx | vy;
							4'h2: v_q[ox] <= vx & vy;
							4'h3: v_q[ox] <= vx ^ vy;
							4'h4: begin
								// flag written last, so it wins for x=F
								if (ox == 4'hF) v_q[15] <= {7'd0, sum[8]};
								else begin
									v_q[ox] <= sum[7:0];
									v_q[15] <= {7'd0, sum[8]};
								end
							end
							4'h5: begin
								// flag first; x=F sees it
								if (ox == 4'hF) v_q[15] <= d5;
								else begin
									v_q[15] <= f5;
									v_q[ox] <= d5;
								end
							end
							4'h6: begin
								if (ox == 4'hF) v_q[15] <= 8'd0;
								else begin
									v_q[15] <= {7'd0, vx[0]};
									v_q[ox] <= {1'b0, vx[7:1]};
								end
							end
							4'h7: begin
								if (ox == 4'hF) v_q[15] <= d7;
								else begin
									v_q[15] <= f7;
									v_q[ox] <= d7;
								end
							end
							4'hE: begin
								if (ox == 4'hF) v_q[15] <= {6'd0, vx[7], 1'b0};
								else begin
									v_q[15] <= {7'd0, vx[7]};
									v_q[ox] <= {vx[6:0], 1'b0};
								end
							end
							default: flt_q <= FLT_BADOP;
						endcase
						4'h9: if (vx != vy) pc_q <= pc_q + 12'd2;
						4'hA: i_q <= {4'd0, req_q.opcode[11:0]};
						4'hB: pc_q <= req_q.opcode[11:0] + {4'd0, v_q[0]};
						4'hC: v_q[ox] <= req_q.random_byte & kk;
						4'hD: begin
							if (on == 4'd0) v_q[15] <= 8'd0;
							else state_q <= ST_MRD;
						end
						4'hE: begin
							if (kk == 8'h9E) begin if (keyp) pc_q <= pc_q + 12'd2; end
							else if (kk == 8'hA1) begin if (!keyp) pc_q <= pc_q + 12'd2; end
							else flt_q <= FLT_BADOP;
						end
						default: case (kk)
							8'h07: v_q[ox] <= dt_q;
							8'h0A: if (req_q.keys_down == 16'd0) wait_q <= 1'b1;
								else v_q[ox] <= {4'd0, lowkey};
							8'h15: dt_q <= vx;
							8'h18: st_q <= vx;
							8'h1E: i_q <= i_q + {8'd0, vx};
							8'h29: i_q <= {8'd0, vx} + {6'd0, vx, 2'b00};
							8'h33: begin bcd_q <= bcd_h; bdig_q <= 2'd0; state_q <= ST_BCD; end
							8'h55, 8'h65: state_q <= ST_MRD;
							default: flt_q <= FLT_BADOP;
						endcase
					endcase
				end
				ST_BCD: begin
					// one digit written per cycle: hundreds, tens, ones
					bdig_q <= bdig_q + 2'd1;
					case (bdig_q)
						2'd0: bcd_q <= {4'd0, bcd_t};
						2'd1: bcd_q <= bcd_o;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_MRD: state_q <= ST_MWAIT;
				ST_MWAIT: state_q <= ST_MUSE;
				ST_MUSE: begin
					if (req_q.opcode[15:12] == 4'hD) begin
						if ((fb_q[ry] & sprite) != 64'd0) hit_q <= 1'b1;
						if (m_rd != 8'd0) chg_q <= 1'b1;
						fb_q[ry] <= fb_q[ry] ^ sprite;
					end else if (kk == 8'h65) v_q[cnt_q[3:0]] <= m_rd;
					cnt_q <= cnt_q + 5'd1;
					if (req_q.opcode[15:12] == 4'hD ? (cnt_q + 5'd1 == {1'b0, on})
						: (cnt_q[3:0] == ox)) begin
						if (req_q.opcode[15:12] == 4'hD)
							v_q[15] <= {7'd0, hit_q || ((fb_q[ry] & sprite) != 64'd0)};
						state_q <= ST_DONE;
					end else state_q <= ST_MRD;
				end
				ST_CLR: begin
					if (fb_q[cnt_q] != 64'd0) chg_q <= 1'b1;
					fb_q[cnt_q] <= '0;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= ST_DONE;
				end
				ST_DONE: begin
					res_q.program_counter <= pc_q;
					res_q.index_value <= i_q;
					res_q.display_row <= fb_q[req_q.row_index];
					res_q.waiting_for_key <= wait_q;
					res_q.display_changed <= chg_q;
					res_q.sound_level <= st_q;
					res_q.fault <= flt_q;
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	property p_nobusy_accept;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_IDLE) |-> !in_ch.ready;
	endproperty
	a_nobusy: assert property (p_nobusy_accept) else $error("accept while busy");
	a_sp: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH)) else $error("stack level out of range");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> ovalid_q) else $error("result lost");
endmodule
`default_nettype wire

### verif/tb_bytecode_vm_execute_unit.sv
// Testbench for the CHIP-8 execute unit: directed and random opcodes against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_bytecode_vm_execute_unit;
	import c8vm_pkg::*;

	localparam int STACK_MAX = 16;
	localparam int CYCLE_LIMIT = 400000;

	// architectural copy of the machine
	class chip8_scoreboard;
		logic [7:0]  vreg [16];
		logic [15:0] ireg;
		logic [11:0] pc;
		int          depth;
		logic [11:0] rstack [STACK_MAX];
		logic [7:0]  delay_t, sound_t;
		logic [7:0]  mem [4096];
		logic [63:0] fb [32];
		vm_out_t     pending [$];
		int          errors, checked;

		function new();
			for (int i = 0; i < 16; i++) vreg[i] = 0;
			ireg = 0; pc = PC_RESET; depth = 0;
			delay_t = 0; sound_t = 0;
			for (int i = 0; i < 4096; i++) mem[i] = (i < FONT_SIZE) ? font_byte(i[6:0]) : 8'h00;
			for (int i = 0; i < 32; i++) fb[i] = '0;
			errors = 0; checked = 0;
		endfunction

		function logic [11:0] maddr(int off);
			return 12'((32'(ireg) + off) % 4096);
		endfunction

		function void skip(bit c);
			if (c) pc = pc + 12'd2;
		endfunction

		function logic [1:0] run_opcode(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd,
			output bit chg, output bit wt);
			logic [3:0] x, y, n;
			logic [7:0] kk;
			logic [8:0] sum;
			logic [63:0] m;
			int sx, sy, r;
			bit hit;
			x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0];
			chg = 0; wt = 0;
			if (op == 16'h00E0) begin
				for (int i = 0; i < 32; i++) begin
					if (fb[i] != 0) chg = 1;
					fb[i] = '0;
				end
				return FLT_NONE;
			end
			if (op == 16'h00EE) begin
				if (depth == 0) return FLT_UNDER;
				depth--;
				pc = rstack[depth];
				return FLT_NONE;
			end
			case (op[15:12])
				4'h1: pc = op[11:0];
				4'h2: begin
					if (depth >= STACK_MAX) return FLT_OVER;
					rstack[depth] = pc; depth++;
					pc = op[11:0];
				end
				4'h3: skip(vreg[x] == kk);
				4'h4: skip(vreg[x] != kk);
				4'h5: skip(vreg[x] == vreg[y]);
				4'h6: vreg[x] = kk;
				4'h7: vreg[x] = vreg[x] + kk;
				4'h8: case (n)
					4'h0: vreg[x] = vreg[y];
					4'h1: vreg[x] = vreg[x] | vreg[y];
					4'h2: vreg[x] = vreg[x] & vreg[y];
					4'h3: vreg[x] = vreg[x] ^ vreg[y];
					4'h4: begin
						sum = vreg[x] + vreg[y];
						vreg[x] = sum[7:0];
						vreg[15] = {7'd0, sum[8]};
					end
					4'h5: begin
						vreg[15] = {7'd0, vreg[x] >= vreg[y]};
						vreg[x] = vreg[x] - vreg[y];
					end
					4'h6: begin
						vreg[15] = {7'd0, vreg[x][0]};
						vreg[x] = vreg[x] >> 1;
					end
					4'h7: begin
						vreg[15] = {7'd0, vreg[y] >= vreg[x]};
						vreg[x] = vreg[y] - vreg[x];
					end
					4'hE: begin
						vreg[15] = {7'd0, vreg[x][7]};
						vreg[x] = vreg[x] << 1;
					end
					default: return FLT_BADOP;
				endcase
				4'h9: skip(vreg[x] != vreg[y]);
				4'hA: ireg = {4'd0, op[11:0]};
				4'hB: pc = op[11:0] + {4'd0, vreg[0]};
				4'hC: vreg[x] = rnd & kk;
				4'hD: begin
					sx = vreg[x] % 64; sy = vreg[y] % 32; hit = 0;
					for (int i = 0; i < n; i++) begin
						m = {mem[maddr(i)], 56'd0};
						r = (sy + i) % 32;
						if (sx != 0) m = (m >> sx) | (m << (64 - sx));
						if ((fb[r] & m) != 0) hit = 1;
						if (m != 0) chg = 1;
						fb[r] = fb[r] ^ m;
					end
					vreg[15] = {7'd0, hit};
				end
				4'hE: begin
					if (kk == 8'h9E) skip(vreg[x] < 16 && keys[vreg[x][3:0]]);
					else if (kk == 8'hA1) skip(!(vreg[x] < 16 && keys[vreg[x][3:0]]));
					else return FLT_BADOP;
				end
				4'hF: case (kk)
					8'h07: vreg[x] = delay_t;
					8'h0A: begin
						if (keys == 0) wt = 1;
						else for (int i = 15; i >= 0; i--) if (keys[i]) vreg[x] = 8'(i);
					end
					8'h15: delay_t = vreg[x];
					8'h18: sound_t = vreg[x];
					8'h1E: ireg = ireg + {8'd0, vreg[x]};
					8'h29: ireg = 16'(vreg[x] * 5);
					8'h33: begin
						mem[maddr(0)] = vreg[x] / 100;
						mem[maddr(1)] = (vreg[x] / 10) % 10;
						mem[maddr(2)] = vreg[x] % 10;
					end
					8'h55: for (int i = 0; i <= x; i++) mem[maddr(i)] = vreg[i];
					8'h65: for (int i = 0; i <= x; i++) vreg[i] = mem[maddr(i)];
					default: return FLT_BADOP;
				endcase
				default: return FLT_BADOP;
			endcase
			return FLT_NONE;
		endfunction

		function void note_input(vm_in_t w);
			vm_out_t e;
			bit chg, wt;
			e = '0;
			chg = 0; wt = 0;
			if (w.operation == OP_EXEC)
				e.fault = run_opcode(w.opcode, w.keys_down, w.random_byte, chg, wt);
			else if (w.operation == OP_WRMEM)
				mem[w.address] = w.data_byte;
			e.program_counter = pc;
			e.index_value = ireg;
			e.display_row = fb[w.row_index];
			e.waiting_for_key = wt;
			e.display_changed = chg;
			e.sound_level = sound_t;
			pending.push_back(e);
		endfunction

		function void check_result(vm_out_t got);
			vm_out_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.program_counter != e.program_counter) begin
				$display("%0t: pc exp %h got %h", $time, e.program_counter, got.program_counter);
				errors++;
			end
			if (got.index_value != e.index_value) begin
				$display("%0t: I exp %h got %h", $time, e.index_value, got.index_value);
				errors++;
			end
			if (got.display_row != e.display_row) begin
				$display("%0t: row exp %h got %h", $time, e.display_row, got.display_row);
				errors++;
			end
			if (got.waiting_for_key != e.waiting_for_key) begin
				$display("%0t: wait exp %b got %b", $time, e.waiting_for_key, got.waiting_for_key);
				errors++;
			end
			if (got.display_changed != e.display_changed) begin
				$display("%0t: changed exp %b got %b", $time, e.display_changed,
					got.display_changed);
				errors++;
			end
			if (got.sound_level != e.sound_level) begin
				$display("%0t: sound exp %h got %h", $time, e.sound_level, got.sound_level);
				errors++;
			end
			if (got.fault != e.fault) begin
				$display("%0t: fault exp %0d got %0d", $time, e.fault, got.fault);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	c8vm_if #(.T(vm_in_t))  in_ch ();
	c8vm_if #(.T(vm_out_t)) out_ch ();

	bytecode_vm_execute_unit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	chip8_scoreboard board;
	int cycles = 0;
	bit calm = 0;  // no random idling while set
	int sent = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// result side
	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);

	always @(negedge clk)
		out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 7);

	// valid stays high into the next word; callers drop it before waiting
	task automatic send_word(vm_in_t w);
		while (!calm && $urandom_range(99) < 7) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.data <= w;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		board.note_input(w);
		sent++;
		@(negedge clk);
	endtask

	task automatic exec(logic [15:0] op, logic [15:0] keys = 16'h0, logic [7:0] rnd = 8'h0);
		vm_in_t w;
		w = '0;
		w.operation = OP_EXEC; w.opcode = op; w.keys_down = keys; w.random_byte = rnd;
		w.row_index = 5'($urandom_range(31));
		send_word(w);
	endtask

	task automatic poke(logic [11:0] a, logic [7:0] d);
		vm_in_t w;
		w = '0;
		w.operation = OP_WRMEM; w.address = a; w.data_byte = d;
		send_word(w);
	endtask

	function automatic logic [15:0] pick_opcode();
		logic [15:0] r;
		logic [7:0] fsub [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
		r = 16'($urandom);
		case ($urandom_range(19))
			0: return 16'h00E0;
			1: return (board.depth > 0) ? 16'h00EE : {4'h2, r[11:0]};
			2: return (board.depth < STACK_MAX) ? {4'h2, r[11:0]} : 16'h00EE;
			3, 4: return {4'h8, r[11:4], 4'($urandom_range(7))};
			5: return {4'h8, r[11:4], 4'hE};
			6, 7: return {4'hD, r[11:4], 4'($urandom_range(8))};
			8: return {4'hE, r[11:8], ($urandom_range(1) ? 8'h9E : 8'hA1)};
			9, 10: return {4'hF, r[11:8], fsub[$urandom_range(8)]};
			11: return r; // noise
			default: return {4'($urandom_range(1, 12)), r[11:0]};
		endcase
	endfunction

	vm_in_t w;
	initial begin
		board = new();
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: register ops, flags, faults, keys, BCD, draws, stack limits, block copies
		exec(16'h60FF); exec(16'h61FF); exec(16'h8014); exec(16'h6F05); exec(16'h8F15);
		exec(16'h8FF7); exec(16'h80E6); exec(16'h8F0E); exec(16'h8008); exec(16'hE0FF);
		exec(16'hF0FF); exec(16'h00EE); exec(16'h0123); exec(16'h5011); exec(16'h9F3F);
		exec(16'hF00A, 16'h0000); exec(16'hF30A, 16'h8000); exec(16'hE39E, 16'h8000);
		exec(16'hE0A1, 16'hFFFF); exec(16'hC2AA, 16'h0, 8'hFF); exec(16'hAFFF);
		exec(16'hF233); exec(16'hF229); exec(16'hD23F); exec(16'hD230); exec(16'h00E0);
		for (int i = 0; i < STACK_MAX + 1; i++) exec({4'h2, 12'(i * 16)});
		for (int i = 0; i < STACK_MAX + 1; i++) exec(16'h00EE);
		exec(16'h60FF); exec(16'hBFFF); exec(16'hF055); exec(16'hFF65);

		// random: mostly valid opcodes, some memory writes, row reads and unused operation codes
		for (int i = 0; i < 900; i++) begin
			calm = (i >= 300 && i < 400);
			if (i == 500) begin
				in_ch.valid <= 1'b0;
				while (board.pending.size() != 0) @(negedge clk);
			end
			w = '0;
			w.keys_down = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom);
			w.random_byte = 8'($urandom);
			w.address = 12'($urandom);
			w.data_byte = 8'($urandom);
			w.row_index = 5'($urandom);
			case ($urandom_range(19))
				0: w.operation = OP_WRMEM;
				1: w.operation = OP_RDROW;
				2: w.operation = 2'd3;
				default: begin
					w.operation = OP_EXEC;
					w.opcode = pick_opcode();
				end
			endcase
			send_word(w);
		end

		in_ch.valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d words (opcodes, memory writes, row reads); checked %0d results.",
			sent, board.checked);
		if (board.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
rtl/c8vm_pkg.sv
rtl/c8vm_if.sv
rtl/c8vm_ram.sv
rtl/bytecode_vm_execute_unit.sv
verif/tb_bytecode_vm_execute_unit.sv
